/* design/resistor_ladder_key_debouncer_assert.svh */
// Assertion macros used by the resistor ladder key debouncer top level.
`ifndef RESISTOR_LADDER_KEY_DEBOUNCER_ASSERT_SVH
`define RESISTOR_LADDER_KEY_DEBOUNCER_ASSERT_SVH

// Condition that must hold at every clock edge outside reset.
`define RLD_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Condition that must hold in the cycle after the trigger.
`define RLD_ASSERT_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cond)) \
    else $error(msg);

`endif

/* design/rld_pkg.sv */
// Types and constants of the resistor ladder key debouncer.
package rld_pkg;

  typedef logic [2:0]  key_t;
  typedef logic [11:0] mv_t;
  typedef logic [31:0] ms_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_KEY1_LEVEL = 3'd0,
    REG_KEY2_LEVEL = 3'd1,
    REG_KEY3_LEVEL = 3'd2,
    REG_KEY4_LEVEL = 3'd3,
    REG_KEY5_LEVEL = 3'd4,
    REG_TOLERANCE  = 3'd5,
    REG_DEBOUNCE   = 3'd6,
    REG_LONG_PRESS = 3'd7
  } reg_idx_e;

  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 16;

  // Voltage at and above which no button is pressed, before tolerance
  localparam mv_t         NoButtonMv = 12'd2800;
  // Fallback match window in units of tolerance
  localparam logic [11:0] WideFactor = 12'd7;

  localparam key_t KeyNone = 3'd0;
  localparam key_t Key1    = 3'd1;
  localparam key_t Key2    = 3'd2;
  localparam key_t Key3    = 3'd3;
  localparam key_t Key4    = 3'd4;
  localparam key_t Key5    = 3'd5;

  typedef struct packed {
    mv_t         level1;
    mv_t         level2;
    mv_t         level3;
    mv_t         level4;
    mv_t         level5;
    logic [8:0]  tolerance;
    logic [7:0]  debounce;
    logic [15:0] long_ms;
  } cfg_t;

endpackage

/* design/rld_decode.sv */
// Ladder voltage to raw key decoder: midpoint buckets then nearest level fallback.
module rld_decode (
  input  rld_pkg::mv_t  sample_mv_i,
  input  rld_pkg::cfg_t cfg_i,
  output rld_pkg::key_t key_o
);
  import rld_pkg::*;

  mv_t         floor_mv;
  mv_t         mid12, mid23, mid34, mid45, mid5f;
  mv_t         d1, d2, d3, d4, d5;
  mv_t         best_d;
  key_t        near_key;
  logic [11:0] window;

  function automatic mv_t midpoint(mv_t a, mv_t b);
    logic [12:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[12:1];
  endfunction

  function automatic mv_t abs_diff(mv_t a, mv_t b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

  // Bucket edges
  assign floor_mv = NoButtonMv - {3'b000, cfg_i.tolerance};
  assign mid12    = midpoint(cfg_i.level1, cfg_i.level2);
  assign mid23    = midpoint(cfg_i.level2, cfg_i.level3);
  assign mid34    = midpoint(cfg_i.level3, cfg_i.level4);
  assign mid45    = midpoint(cfg_i.level4, cfg_i.level5);
  assign mid5f    = midpoint(cfg_i.level5, floor_mv);

  // Distances to each nominal level
  assign d1 = abs_diff(sample_mv_i, cfg_i.level1);
  assign d2 = abs_diff(sample_mv_i, cfg_i.level2);
  assign d3 = abs_diff(sample_mv_i, cfg_i.level3);
  assign d4 = abs_diff(sample_mv_i, cfg_i.level4);
  assign d5 = abs_diff(sample_mv_i, cfg_i.level5);

  // Tolerance at most 511, so seven times it fits in 12 bits
  assign window = 12'({3'b000, cfg_i.tolerance} * WideFactor);

  // Nearest level, lower key kept on a tie
  always_comb begin
    best_d   = d1;
    near_key = Key1;
    if (d2 < best_d) begin
      best_d   = d2;
      near_key = Key2;
    end
    if (d3 < best_d) begin
      best_d   = d3;
      near_key = Key3;
    end
    if (d4 < best_d) begin
      best_d   = d4;
      near_key = Key4;
    end
    if (d5 < best_d) begin
      best_d   = d5;
      near_key = Key5;
    end
  end

  // Bucket selection in priority order
  always_comb begin
    priority if (sample_mv_i >= floor_mv) key_o = KeyNone;
    else if (sample_mv_i <= mid12)        key_o = Key1;
    else if (sample_mv_i <= mid23)        key_o = Key2;
    else if (sample_mv_i <= mid34)        key_o = Key3;
    else if (sample_mv_i <= mid45)        key_o = Key4;
    else if (sample_mv_i <= mid5f)        key_o = Key5;
    else if (best_d <= window)            key_o = near_key;
    else                                  key_o = KeyNone;
  end

endmodule

/* design/resistor_ladder_key_debouncer.sv */
// Top level of the resistor ladder key debouncer with long press detection.
//
//  channel  | direction | tdata fields (low bit up)             | tuser
//  ---------+-----------+---------------------------------------+------
//  s_axis   | in        | sample_mv[11:0], now_ms[43:12], pad   | none
//  m_axis   | out       | key_released[2:0], long_hold[3], pad  | none
//  cfg      | in        | cfg_we_i, cfg_addr_i, cfg_wdata_i     | none
//
// One sample per cycle sustained while m_axis takes each result: input register, decode and
// debounce logic, result register. A result moves from the input register to the result register.
// A sample may give no result; then nothing appears on m_axis.
// Reset restores the register defaults and clears key and time state.
// A stalled result holds the pipeline only while the input register is full.
module resistor_ladder_key_debouncer (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [rld_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [rld_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                         s_tvalid_i,
  output logic                         s_tready_o,
  input  logic [47:0]                  s_tdata_i,   // sample_mv[11:0], now_ms[43:12]
  output logic                         m_tvalid_o,
  input  logic                         m_tready_i,
  output logic [7:0]                   m_tdata_o    // key_released[2:0], long_hold[3]
);
  import rld_pkg::*;

  cfg_t  cfg_q;

  logic  in_valid_q;
  mv_t   in_mv_q;
  ms_t   in_now_q;

  key_t  raw_key_q, raw_key_d;
  ms_t   raw_time_q, raw_time_d;
  key_t  stable_key_q, stable_key_d;
  ms_t   press_time_q, press_time_d;

  logic  out_valid_q, out_valid_d;
  key_t  out_key_q, out_key_d;
  logic  out_long_q, out_long_d;

  key_t  dec_key;
  logic  advance;
  logic  emit;
  ms_t   change_time;
  ms_t   since_change;
  ms_t   hold;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.level1    <= 12'd0;
      cfg_q.level2    <= 12'd500;
      cfg_q.level3    <= 12'd1000;
      cfg_q.level4    <= 12'd1500;
      cfg_q.level5    <= 12'd2000;
      cfg_q.tolerance <= 9'd100;
      cfg_q.debounce  <= 8'd30;
      cfg_q.long_ms   <= 16'd1000;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_addr_i))
        REG_KEY1_LEVEL: cfg_q.level1    <= cfg_wdata_i[11:0];
        REG_KEY2_LEVEL: cfg_q.level2    <= cfg_wdata_i[11:0];
        REG_KEY3_LEVEL: cfg_q.level3    <= cfg_wdata_i[11:0];
        REG_KEY4_LEVEL: cfg_q.level4    <= cfg_wdata_i[11:0];
        REG_KEY5_LEVEL: cfg_q.level5    <= cfg_wdata_i[11:0];
        REG_TOLERANCE:  cfg_q.tolerance <= cfg_wdata_i[8:0];
        REG_DEBOUNCE:   cfg_q.debounce  <= cfg_wdata_i[7:0];
        REG_LONG_PRESS: cfg_q.long_ms   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Handshake: the input register moves on whenever the result register is free
  assign advance    = !out_valid_q || m_tready_i;
  assign s_tready_o = !in_valid_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_tready_o) begin
      in_valid_q <= s_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_tready_o && s_tvalid_i) begin
      in_mv_q  <= s_tdata_i[11:0];
      in_now_q <= s_tdata_i[43:12];
    end
  end

  rld_decode u_decode (
    .sample_mv_i (in_mv_q),
    .cfg_i       (cfg_q),
    .key_o       (dec_key)
  );

  // Debounce and hold tracking
  assign change_time  = (dec_key != raw_key_q) ? in_now_q : raw_time_q;
  assign since_change = in_now_q - change_time;
  assign hold         = in_now_q - press_time_q;

  always_comb begin
    raw_key_d    = raw_key_q;
    raw_time_d   = raw_time_q;
    stable_key_d = stable_key_q;
    press_time_d = press_time_q;
    emit         = 1'b0;
    out_key_d    = out_key_q;
    out_long_d   = out_long_q;
    out_valid_d  = out_valid_q && !m_tready_i;
    if (in_valid_q && advance) begin
      raw_key_d   = dec_key;
      raw_time_d  = change_time;
      out_valid_d = 1'b0;
      if (since_change >= {24'd0, cfg_q.debounce} && dec_key != stable_key_q) begin
        stable_key_d = dec_key;
        if (stable_key_q == KeyNone) begin
          press_time_d = in_now_q;
        end else begin
          press_time_d = (dec_key != KeyNone) ? in_now_q : '0;
          if (hold >= {24'd0, cfg_q.debounce}) begin
            emit        = 1'b1;
            out_valid_d = 1'b1;
            out_key_d   = stable_key_q;
            out_long_d  = hold >= {16'd0, cfg_q.long_ms};
          end
        end
      end
    end
  end

  // State and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_key_q    <= KeyNone;
      raw_time_q   <= '0;
      stable_key_q <= KeyNone;
      press_time_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      raw_key_q    <= raw_key_d;
      raw_time_q   <= raw_time_d;
      stable_key_q <= stable_key_d;
      press_time_q <= press_time_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_key_q  <= out_key_d;
    out_long_q <= out_long_d;
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {4'b0000, out_long_q, out_key_q};

  // Checks
`include "resistor_ladder_key_debouncer_assert.svh"

  `RLD_ASSERT(a_result_key, !out_valid_q || (out_key_q != KeyNone && out_key_q <= Key5), "bad key")
  `RLD_ASSERT(a_idle_press_time, stable_key_q != KeyNone || press_time_q == '0, "stray press time")
  `RLD_ASSERT(a_empty_input_ready, in_valid_q || s_tready_o, "empty input register not ready")
  `RLD_ASSERT_NEXT(a_emit_changes_key, emit, stable_key_q != $past(stable_key_q), "no key change")
  `RLD_ASSERT(a_raw_key_range, raw_key_q <= Key5, "raw key out of range")

endmodule

/* dv/resistor_ladder_key_debouncer_tb.sv */
// Testbench of the resistor ladder key debouncer: directed press table, then random press episodes.
`timescale 1ns / 100ps

module resistor_ladder_key_debouncer_tb;
  import rld_pkg::*;

  typedef int unsigned u32_t;

  // How a directed row is checked
  typedef enum logic [1:0] {
    CHK_PREDICT    = 2'd0,
    CHK_NO_RELEASE = 2'd1,
    CHK_RELEASE    = 2'd2
  } chk_e;

  typedef struct packed {
    key_t key;
    logic lng;
  } release_t;

  typedef struct packed {
    mv_t  mv;
    ms_t  now;
    chk_e chk;
    key_t key;
    logic lng;
  } stim_row_t;

  localparam int WatchdogCycles = 5000;
  localparam int PhaseItems     = 128;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [2:0]  cfg_addr_i  = '0;
  logic [15:0] cfg_wdata_i = '0;
  logic        s_tvalid_i  = 1'b0;
  logic        s_tready_o;
  logic [47:0] s_tdata_i   = '0;  // sample_mv[11:0], now_ms[43:12]
  logic        m_tvalid_o;
  logic        m_tready_i  = 1'b0;
  logic [7:0]  m_tdata_o;         // key_released[2:0], long_hold[3]

  resistor_ladder_key_debouncer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s_tvalid_i  (s_tvalid_i),
    .s_tready_o  (s_tready_o),
    .s_tdata_i   (s_tdata_i),
    .m_tvalid_o  (m_tvalid_o),
    .m_tready_i  (m_tready_i),
    .m_tdata_o   (m_tdata_o)
  );

  always #5 clk_i = ~clk_i;

  // Predictor copy of the registers and the key tracking state
  mv_t         level_cfg [5];
  logic [8:0]  tol_cfg;
  logic [7:0]  debounce_cfg;
  logic [15:0] long_cfg;
  key_t        raw_key_q;
  key_t        stable_key_q;
  ms_t         raw_since_q;
  ms_t         press_since_q;

  release_t release_q [$];
  release_t head_release;

  ms_t stamp_ms      = '0;
  int  items_sent    = 0;
  int  mismatches    = 0;
  int  releases_seen = 0;
  int  rx_gap        = 0;
  int  rx_hold       = 0;
  int  rx_cycles     = 0;
  int  quiet_cycles  = 0;

  // Directed table, run with the register defaults straight after reset
  stim_row_t directed_rows [25] = '{
    '{12'd4095, 32'd0,          CHK_NO_RELEASE, KeyNone, 1'b0},
    '{12'd0,    32'd100,        CHK_NO_RELEASE, KeyNone, 1'b0},
    '{12'd0,    32'd130,        CHK_NO_RELEASE, KeyNone, 1'b0},
    '{12'd4095, 32'd140,        CHK_NO_RELEASE, KeyNone, 1'b0},
    '{12'd4095, 32'd170,        CHK_RELEASE,    Key1,    1'b0},
    '{12'd2000, 32'd200,        CHK_NO_RELEASE, KeyNone, 1'b0},
    '{12'd2699, 32'd230,        CHK_PREDICT,    KeyNone, 1'b0},  // nearest-level fallback
    '{12'd2800, 32'd1230,       CHK_NO_RELEASE, KeyNone, 1'b0},
    '{12'd2800, 32'd1260,       CHK_RELEASE,    Key5,    1'b1},
    '{12'd1000, 32'd2000,       CHK_NO_RELEASE, KeyNone, 1'b0},
    '{12'd1000, 32'd2030,       CHK_NO_RELEASE, KeyNone, 1'b0},
    '{12'd1500, 32'd2040,       CHK_NO_RELEASE, KeyNone, 1'b0},
    '{12'd1500, 32'd2035,       CHK_NO_RELEASE, KeyNone, 1'b0},  // short hold, time steps back
    '{12'd4095, 32'd2100,       CHK_NO_RELEASE, KeyNone, 1'b0},
    '{12'd4095, 32'd2130,       CHK_RELEASE,    Key4,    1'b0},
    '{12'd500,  32'hFFFF_FFF0,  CHK_NO_RELEASE, KeyNone, 1'b0},
    '{12'd500,  32'h0000_0010,  CHK_NO_RELEASE, KeyNone, 1'b0},  // settles across the wrap
    '{12'd4095, 32'h0000_0020,  CHK_NO_RELEASE, KeyNone, 1'b0},
    '{12'd4095, 32'h0000_0040,  CHK_RELEASE,    Key2,    1'b0},
    '{12'd500,  32'h0000_0100,  CHK_NO_RELEASE, KeyNone, 1'b0},
    '{12'd500,  32'h0000_0120,  CHK_NO_RELEASE, KeyNone, 1'b0},
    '{12'd1000, 32'h0000_0200,  CHK_NO_RELEASE, KeyNone, 1'b0},
    '{12'd1000, 32'h0000_0220,  CHK_RELEASE,    Key2,    1'b0},  // key replaced by another
    '{12'd2351, 32'h0000_0700,  CHK_PREDICT,    KeyNone, 1'b0},
    '{12'd4095, 32'hFFFF_FFFF,  CHK_PREDICT,    KeyNone, 1'b0}
  };

  task automatic reset_predictor();
    level_cfg[0]  = 12'd0;
    level_cfg[1]  = 12'd500;
    level_cfg[2]  = 12'd1000;
    level_cfg[3]  = 12'd1500;
    level_cfg[4]  = 12'd2000;
    tol_cfg       = 9'd100;
    debounce_cfg  = 8'd30;
    long_cfg      = 16'd1000;
    raw_key_q     = KeyNone;
    stable_key_q  = KeyNone;
    raw_since_q   = '0;
    press_since_q = '0;
  endtask

  // Ladder voltage to raw key: midpoint buckets, then nearest level within the wide window
  function automatic key_t decode_ladder(input mv_t mv);
    u32_t floor_mv;
    u32_t best_d;
    u32_t delta;
    key_t best;
    int   i;
    floor_mv = u32_t'(NoButtonMv) - u32_t'(tol_cfg);
    if (u32_t'(mv) >= floor_mv) return KeyNone;
    for (i = 0; i < 4; i++) begin
      if (u32_t'(mv) <= (u32_t'(level_cfg[i]) + u32_t'(level_cfg[i + 1])) / 2)
        return key_t'(i + 1);
    end
    if (u32_t'(mv) <= (u32_t'(level_cfg[4]) + floor_mv) / 2) return Key5;
    best   = Key1;
    best_d = '0;
    for (i = 0; i < 5; i++) begin
      delta = (mv >= level_cfg[i]) ? u32_t'(mv) - u32_t'(level_cfg[i])
                                   : u32_t'(level_cfg[i]) - u32_t'(mv);
      // strict compare keeps the lower key on a tie
      if (i == 0 || delta < best_d) begin
        best_d = delta;
        best   = key_t'(i + 1);
      end
    end
    if (best_d <= u32_t'(tol_cfg) * u32_t'(WideFactor)) return best;
    return KeyNone;
  endfunction

  // Debounce and hold tracking for one sample; returns 1 when a press ends with a report
  function automatic bit advance_press(input mv_t mv, input ms_t now, output release_t rel);
    key_t k;
    key_t ended;
    ms_t  settled;
    ms_t  hold;
    rel = '0;
    k   = decode_ladder(mv);
    if (k != raw_key_q) begin
      raw_key_q   = k;
      raw_since_q = now;
    end
    settled = now - raw_since_q;
    if (settled < u32_t'(debounce_cfg)) return 1'b0;
    if (raw_key_q == stable_key_q) return 1'b0;
    if (stable_key_q == KeyNone) begin
      stable_key_q  = raw_key_q;
      press_since_q = now;
      return 1'b0;
    end
    ended         = stable_key_q;
    hold          = now - press_since_q;
    stable_key_q  = raw_key_q;
    press_since_q = (raw_key_q != KeyNone) ? now : '0;
    if (hold < u32_t'(debounce_cfg)) return 1'b0;
    rel.key = ended;
    rel.lng = (hold >= u32_t'(long_cfg));
    return 1'b1;
  endfunction

  // Idle length: mostly none, sometimes short, rarely long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 15);
    if (r < 9) return 0;
    if (r < 14) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  function automatic mv_t ladder_mv(input key_t k);
    int v;
    v = int'(level_cfg[int'(k) - 1]) + int'($urandom_range(0, 2 * int'(tol_cfg)))
        - int'(tol_cfg);
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return mv_t'(v);
  endfunction

  function automatic mv_t release_mv();
    return mv_t'($urandom_range(4095, u32_t'(NoButtonMv) - u32_t'(tol_cfg)));
  endfunction

  // Offer one item, wait for the handshake, then record what it should cause
  task automatic send_item(input mv_t mv, input ms_t now, input chk_e chk,
                           input key_t key, input logic lng);
    int       gap;
    release_t rel;
    bit       got;
    gap = ((items_sent / 40) % 3 == 0) ? 0 : idle_len();
    repeat (gap) begin
      @(negedge clk_i);
      s_tvalid_i <= 1'b0;
    end
    @(negedge clk_i);
    s_tvalid_i <= 1'b1;
    s_tdata_i  <= {4'b0, now, mv};
    do @(posedge clk_i); while (!s_tready_o);
    items_sent++;
    got = advance_press(mv, now, rel);
    case (chk)
      CHK_PREDICT: if (got) release_q.push_back(rel);
      CHK_RELEASE: release_q.push_back('{key: key, lng: lng});
      default: ;
    endcase
  endtask

  // Drop valid, let every pending release out and the pipeline empty
  task automatic settle();
    @(negedge clk_i);
    s_tvalid_i <= 1'b0;
    while (release_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic cfg_write(input reg_idx_e idx, input logic [15:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= value;
    case (idx)
      REG_KEY1_LEVEL: level_cfg[0] = value[11:0];
      REG_KEY2_LEVEL: level_cfg[1] = value[11:0];
      REG_KEY3_LEVEL: level_cfg[2] = value[11:0];
      REG_KEY4_LEVEL: level_cfg[3] = value[11:0];
      REG_KEY5_LEVEL: level_cfg[4] = value[11:0];
      REG_TOLERANCE:  tol_cfg      = value[8:0];
      REG_DEBOUNCE:   debounce_cfg = value[7:0];
      REG_LONG_PRESS: long_cfg     = value;
      default: ;
    endcase
  endtask

  // Rewrite every register; unused upper data bits carry noise
  task automatic reconfigure(input mv_t l1, input mv_t l2, input mv_t l3, input mv_t l4,
                             input mv_t l5, input logic [8:0] tol, input logic [7:0] deb,
                             input logic [15:0] lp);
    settle();
    cfg_write(REG_KEY1_LEVEL, {4'($urandom), l1});
    cfg_write(REG_KEY2_LEVEL, {4'($urandom), l2});
    cfg_write(REG_KEY3_LEVEL, {4'($urandom), l3});
    cfg_write(REG_KEY4_LEVEL, {4'($urandom), l4});
    cfg_write(REG_KEY5_LEVEL, {4'($urandom), l5});
    cfg_write(REG_TOLERANCE,  {7'($urandom), tol});
    cfg_write(REG_DEBOUNCE,   {8'($urandom), deb});
    cfg_write(REG_LONG_PRESS, lp);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // One press: optional bounce, settle, hold, then release or another key
  task automatic press_episode();
    key_t k;
    key_t rk;
    mv_t  rv;
    int   dt;
    int   hold;
    int   n;
    k = key_t'($urandom_range(1, 5));
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        stamp_ms += $urandom_range(0, 3);
        send_item(mv_t'($urandom), stamp_ms, CHK_PREDICT, KeyNone, 1'b0);
      end
    end
    stamp_ms += $urandom_range(1, 3);
    send_item(ladder_mv(k), stamp_ms, CHK_PREDICT, KeyNone, 1'b0);
    dt = int'(debounce_cfg) + int'($urandom_range(0, 2))
         - (($urandom_range(0, 5) == 0) ? 1 : 0);
    if (dt < 0) dt = 0;
    stamp_ms += dt;
    send_item(ladder_mv(k), stamp_ms, CHK_PREDICT, KeyNone, 1'b0);
    case ($urandom_range(0, 3))
      0:       hold = $urandom_range(0, 2 * int'(debounce_cfg) + 2);
      1:       hold = int'(long_cfg) + int'($urandom_range(0, 4)) - 2;
      2:       hold = $urandom_range(0, 2 * int'(long_cfg) + 10);
      default: hold = $urandom_range(0, 300);
    endcase
    if (hold < 0) hold = 0;
    n = $urandom_range(1, 3);
    repeat (n) begin
      stamp_ms += hold / n;
      send_item(ladder_mv(k), stamp_ms, CHK_PREDICT, KeyNone, 1'b0);
    end
    rk = ($urandom_range(0, 3) == 0) ? key_t'($urandom_range(1, 5)) : KeyNone;
    rv = (rk == KeyNone) ? release_mv() : ladder_mv(rk);
    stamp_ms += $urandom_range(0, 2);
    send_item(rv, stamp_ms, CHK_PREDICT, KeyNone, 1'b0);
    stamp_ms += int'(debounce_cfg) + int'($urandom_range(0, 2));
    send_item(rv, stamp_ms, CHK_PREDICT, KeyNone, 1'b0);
  endtask

  // Mostly press episodes, some noise items and timestamp jumps
  task automatic run_random(input int n_items);
    int start;
    int r;
    start = items_sent;
    while (items_sent - start < n_items) begin
      r = $urandom_range(0, 9);
      if (r == 0) begin
        send_item(mv_t'($urandom), ms_t'($urandom), CHK_PREDICT, KeyNone, 1'b0);
      end else if (r == 1) begin
        stamp_ms = $urandom_range(0, 1) ? ms_t'($urandom)
                                        : 32'hFFFF_FFFF - $urandom_range(0, 80);
      end else begin
        press_episode();
      end
    end
  endtask

  task automatic note_mismatch(input string what, input int want, input int got);
    if (mismatches < 10)
      $display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, want, got);
    mismatches++;
  endtask

  // Result checker
  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid_o && m_tready_i) begin
      releases_seen++;
      if (releases_seen == 20) rx_hold = 300;
      if (release_q.size() == 0) begin
        note_mismatch("result with nothing pending, key", 0, int'(m_tdata_o[2:0]));
      end else begin
        head_release = release_q.pop_front();
        if (m_tdata_o[2:0] != head_release.key)
          note_mismatch("key_released", int'(head_release.key), int'(m_tdata_o[2:0]));
        if (m_tdata_o[3] != head_release.lng)
          note_mismatch("long hold flag", int'(head_release.lng), int'(m_tdata_o[3]));
      end
    end
  end

  // Receiver: random gaps, plus one long hold-off to back the block up
  always @(negedge clk_i) begin
    rx_cycles++;
    if (rx_hold > 0) begin
      rx_hold--;
      m_tready_i <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      m_tready_i <= 1'b0;
    end else begin
      m_tready_i <= 1'b1;
      if ((rx_cycles / 150) % 3 != 0) rx_gap = idle_len();
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((s_tvalid_i && s_tready_o) || (m_tvalid_o && m_tready_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WatchdogCycles) begin
        $display("** resistor_ladder_key_debouncer: FAILED **");
        $finish;
      end
    end
  end

  // Main sequence
  initial begin
    reset_predictor();
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i])
      send_item(directed_rows[i].mv, directed_rows[i].now, directed_rows[i].chk,
                directed_rows[i].key, directed_rows[i].lng);

    // zero tolerance, debounce and long press
    reconfigure(12'd0, 12'd500, 12'd1000, 12'd1500, 12'd2000, 9'd0, 8'd0, 16'd0);
    run_random(PhaseItems);
    // widest tolerance, debounce and long press
    reconfigure(12'd0, 12'd500, 12'd1000, 12'd1500, 12'd2000, 9'd511, 8'd255, 16'hFFFF);
    run_random(PhaseItems);
    // levels out of order
    reconfigure(12'd3000, 12'd200, 12'd2500, 12'd700, 12'd4095, 9'd400, 8'd30, 16'd1000);
    run_random(PhaseItems);
    // all levels equal at the bottom, ties go to the lower key
    reconfigure(12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 9'd200, 8'd5, 16'd50);
    run_random(PhaseItems);
    // all levels at the top
    reconfigure(12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 9'd100, 8'd10, 16'd100);
    run_random(PhaseItems);
    // ascending random ladders
    repeat (2) begin
      reconfigure(mv_t'($urandom_range(0, 200)), mv_t'($urandom_range(300, 700)),
                  mv_t'($urandom_range(800, 1200)), mv_t'($urandom_range(1300, 1700)),
                  mv_t'($urandom_range(1800, 2200)), 9'($urandom_range(0, 400)),
                  8'($urandom), 16'($urandom_range(0, 3000)));
      run_random(PhaseItems);
    end
    // anything goes
    reconfigure(mv_t'($urandom), mv_t'($urandom), mv_t'($urandom), mv_t'($urandom),
                mv_t'($urandom), 9'($urandom), 8'($urandom), 16'($urandom));
    run_random(PhaseItems);

    @(negedge clk_i);
    s_tvalid_i <= 1'b0;
    while (release_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && release_q.size() == 0) begin
      $display("** resistor_ladder_key_debouncer: PASSED **");
    end else begin
      $display("** resistor_ladder_key_debouncer: FAILED **");
    end
    $finish;
  end

endmodule
